/* hdl/dnt_pkg.sv */
// ----------------------------------------------------------------------------
// dnt_pkg
// Types, constants and helpers for the DNS name wire-to-text converter.
// ----------------------------------------------------------------------------
package dnt_pkg;

  localparam int MAX_TEXT_SIZE = 1024;
  localparam int SIZE_W        = 11;
  localparam int LEN_W         = 10;
  localparam int LABEL_W       = 6;
  localparam int MAX_RESULTS   = 4;
  localparam int CNT_W         = 3;
  localparam int IDX_W         = 2;

  localparam logic [7:0] MAX_LABEL = 8'd64;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7f;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  localparam logic [SIZE_W-1:0] DEST_SIZE_RST = SIZE_W'(MAX_TEXT_SIZE);

  typedef enum logic [1:0] {
    ST_CHAR = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       start_of_name;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_char;
    logic             char_valid;
    logic             last;
    status_t          status;
    logic [LEN_W-1:0] text_length;
  } result_t;

  function automatic result_t mk_char(input logic [7:0] ch);
    result_t r;
    r.out_char    = ch;
    r.char_valid  = 1'b1;
    r.last        = 1'b0;
    r.status      = ST_CHAR;
    r.text_length = '0;
    return r;
  endfunction

  function automatic result_t mk_err();
    result_t r;
    r.out_char    = '0;
    r.char_valid  = 1'b0;
    r.last        = 1'b1;
    r.status      = ST_ERR;
    r.text_length = '0;
    return r;
  endfunction

  function automatic result_t mk_term(input logic [SIZE_W-1:0] len);
    result_t r;
    r.out_char    = '0;
    r.char_valid  = 1'b1;
    r.last        = 1'b1;
    r.status      = ST_DONE;
    r.text_length = len[LEN_W-1:0];
    return r;
  endfunction

  // C + need <= S, no wrap
  function automatic logic has_room(input logic [SIZE_W-1:0] cw,
                                    input logic [SIZE_W-1:0] lim,
                                    input logic [2:0]        need);
    logic [SIZE_W:0] sum;
    sum = {1'b0, cw} + (SIZE_W+1)'(need);
    return sum <= {1'b0, lim};
  endfunction

  function automatic logic needs_quote(input logic [7:0] c);
    return c == 8'h22 || c == 8'h2e || c == 8'h3b || c == 8'h5c ||
           c == 8'h28 || c == 8'h29 || c == 8'h40 || c == 8'h24;
  endfunction

  // Three ASCII decimal digits via reciprocal multiplies (exact for 0..255)
  function automatic logic [23:0] dec3(input logic [7:0] b);
    logic [13:0] ph;
    logic [1:0]  h;
    logic [6:0]  r100;
    logic [14:0] pt;
    logic [3:0]  t;
    logic [3:0]  u;
    ph   = 14'(b) * 14'd41;
    h    = ph[13:12];
    r100 = 7'(b - 8'(h) * 8'd100);
    pt   = 15'(r100) * 15'd205;
    t    = pt[14:11];
    u    = 4'(r100 - 7'(t) * 7'd10);
    return {CH_ZERO + 8'(h), CH_ZERO + 8'(t), CH_ZERO + 8'(u)};
  endfunction

endpackage

/* hdl/dnt_if.sv */
// ----------------------------------------------------------------------------
// dnt_if
// Valid/ready channel interfaces for name octets and text results.
// ----------------------------------------------------------------------------
interface dnt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_byte;
  logic       start_of_name;

  modport source (output valid, output name_byte, output start_of_name, input ready);
  modport sink   (input valid, input name_byte, input start_of_name, output ready);
endinterface

interface dnt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       last;
  logic [1:0] status;
  logic [9:0] text_length;

  modport source (output valid, output out_char, output char_valid, output last,
                  output status, output text_length, input ready);
  modport sink   (input valid, input out_char, input char_valid, input last,
                  input status, input text_length, output ready);
endinterface

/* hdl/dnt_skid.sv */
// ----------------------------------------------------------------------------
// dnt_skid
// Two-entry output buffer; upstream ready comes from a register only.
// ----------------------------------------------------------------------------
module dnt_skid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  dnt_pkg::result_t up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output dnt_pkg::result_t dn_data
);
  import dnt_pkg::*;

  result_t    head_r, tail_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign up_ready = (cnt_r != 2'd2);
  assign dn_valid = (cnt_r != 2'd0);
  assign dn_data  = head_r;
  assign push     = up_valid && up_ready;
  assign pop      = dn_valid && dn_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    priority if (pop && cnt_r == 2'd2) begin
      head_r <= tail_r;
      if (push) begin
        tail_r <= up_data;
      end
    end else if (pop) begin
      if (push) begin
        head_r <= up_data;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        head_r <= up_data;
      end else begin
        tail_r <= up_data;
      end
    end
  end

endmodule

/* hdl/dnt_engine.sv */
// ----------------------------------------------------------------------------
// dnt_engine
// Name state, per-octet burst of up to four results, and burst sequencer.
// ----------------------------------------------------------------------------
module dnt_engine (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [dnt_pkg::SIZE_W-1:0]   cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  dnt_pkg::in_item_t            in_item,
  output logic                         res_valid,
  input  logic                         res_ready,
  output dnt_pkg::result_t             res_data
);
  import dnt_pkg::*;

  logic [SIZE_W-1:0]  dest_size_r;
  logic [LABEL_W-1:0] lr_r, lr_nxt;
  logic [SIZE_W-1:0]  cw_r, cw_nxt;
  logic               disc_r, disc_nxt;
  result_t            burst_r [MAX_RESULTS];
  result_t            nb      [MAX_RESULTS];
  logic [CNT_W-1:0]   rem_r, n;
  logic [IDX_W-1:0]   idx_r;
  logic               fire, send;

  logic [SIZE_W-1:0]  lim;
  logic [LABEL_W-1:0] lr;
  logic [SIZE_W-1:0]  cw;
  logic               disc;
  logic [7:0]         b;
  logic [23:0]        digits;

  assign lim    = (dest_size_r > SIZE_W'(MAX_TEXT_SIZE)) ? SIZE_W'(MAX_TEXT_SIZE)
                                                          : dest_size_r;
  assign b      = in_item.name_byte;
  assign digits = dec3(b);

  assign send      = (rem_r != '0) && res_ready;
  assign in_ready  = (rem_r == '0) || (rem_r == CNT_W'(1) && res_ready);
  assign fire      = in_valid && in_ready;
  assign res_valid = (rem_r != '0);
  assign res_data  = burst_r[idx_r];

  always_comb begin
    lr   = lr_r;
    cw   = cw_r;
    disc = disc_r;
    if (in_item.start_of_name) begin
      lr   = '0;
      cw   = '0;
      disc = 1'b0;
    end
    for (int i = 0; i < MAX_RESULTS; i++) begin
      nb[i] = '0;
    end
    n        = '0;
    lr_nxt   = lr;
    cw_nxt   = cw;
    disc_nxt = disc;
    if (!disc) begin
      if (lr == '0) begin
        if (b == 8'd0) begin
          disc_nxt = 1'b1;
          if (cw == '0) begin
            // root name: a lone dot, then the terminator, or an error when out of room
            if (!has_room(cw, lim, 3'd1)) begin
              nb[0] = mk_err();
              n     = CNT_W'(1);
            end else if (!has_room(cw, lim, 3'd2)) begin
              nb[0]  = mk_char(CH_DOT);
              nb[1]  = mk_err();
              n      = CNT_W'(2);
              cw_nxt = SIZE_W'(1);
            end else begin
              nb[0]  = mk_char(CH_DOT);
              nb[1]  = mk_term(SIZE_W'(1));
              n      = CNT_W'(2);
              cw_nxt = SIZE_W'(1);
            end
          end else if (!has_room(cw, lim, 3'd1)) begin
            nb[0] = mk_err();
            n     = CNT_W'(1);
          end else begin
            nb[0] = mk_term(cw);
            n     = CNT_W'(1);
          end
        end else if (b >= MAX_LABEL || (cw != '0 && !has_room(cw, lim, 3'd1))) begin
          nb[0]    = mk_err();
          n        = CNT_W'(1);
          disc_nxt = 1'b1;
        end else begin
          if (cw != '0) begin
            nb[0]  = mk_char(CH_DOT);
            n      = CNT_W'(1);
            cw_nxt = cw + SIZE_W'(1);
          end
          lr_nxt = b[LABEL_W-1:0];
        end
      end else begin
        lr_nxt = lr - LABEL_W'(1);
        if (needs_quote(b)) begin
          if (has_room(cw, lim, 3'd2)) begin
            nb[0]  = mk_char(CH_BSLASH);
            nb[1]  = mk_char(b);
            n      = CNT_W'(2);
            cw_nxt = cw + SIZE_W'(2);
          end else begin
            nb[0]    = mk_err();
            n        = CNT_W'(1);
            disc_nxt = 1'b1;
            lr_nxt   = '0;
          end
        end else if (b <= CH_SPACE || b >= CH_DEL) begin
          if (has_room(cw, lim, 3'd4)) begin
            nb[0]  = mk_char(CH_BSLASH);
            nb[1]  = mk_char(digits[23:16]);
            nb[2]  = mk_char(digits[15:8]);
            nb[3]  = mk_char(digits[7:0]);
            n      = CNT_W'(4);
            cw_nxt = cw + SIZE_W'(4);
          end else begin
            nb[0]    = mk_err();
            n        = CNT_W'(1);
            disc_nxt = 1'b1;
            lr_nxt   = '0;
          end
        end else begin
          if (has_room(cw, lim, 3'd2)) begin
            nb[0]  = mk_char(b);
            n      = CNT_W'(1);
            cw_nxt = cw + SIZE_W'(1);
          end else begin
            nb[0]    = mk_err();
            n        = CNT_W'(1);
            disc_nxt = 1'b1;
            lr_nxt   = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_size_r <= DEST_SIZE_RST;
      lr_r        <= '0;
      cw_r        <= '0;
      disc_r      <= 1'b1;
      rem_r       <= '0;
      idx_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        dest_size_r <= cfg_wr_data;
      end
      if (fire) begin
        lr_r   <= lr_nxt;
        cw_r   <= cw_nxt;
        disc_r <= disc_nxt;
        rem_r  <= n;
        idx_r  <= '0;
      end else if (send) begin
        rem_r <= rem_r - CNT_W'(1);
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        burst_r[i] <= nb[i];
      end
    end
  end

`ifndef SYNTHESIS
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= CNT_W'(MAX_RESULTS))
    else $error("burst count out of range");

  a_last_final: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r > CNT_W'(1) |-> !res_data.last)
    else $error("last flag before end of burst");

  a_discard_silent: assert property (@(posedge clk) disable iff (!rst_n)
    fire && disc_r && !in_item.start_of_name |=> rem_r == '0 && disc_r)
    else $error("result produced while discarding");

  a_cw_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cw_r <= SIZE_W'(MAX_TEXT_SIZE))
    else $error("character count beyond text space");
`endif

endmodule

/* hdl/dns_name_wire_to_text_top.sv */
// ----------------------------------------------------------------------------
// dns_name_wire_to_text_top
// Streams a wire-format DNS name into presentation text, one char per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one name octet per transfer; start_of_name flags the first octet
//            of a name and restarts the converter even inside a label.
//   out_ch : one text character, terminator or error per transfer; last marks
//            the final transfer of a name.
//   cfg_*  : dest_size written with cfg_wr_en; the user writes it only while
//            the block is idle, and the block does no check of this.
// Order: results are registered in the burst sequencer, then the output buffer.
// Throughput: one octet per cycle while each gives at most one result and
//   the buffer has room; an octet giving more results (escape: up to 4) holds
//   the input while the sequencer emits them, one per cycle as room allows.
// Reset: dest_size returns to 1024 and octets are dropped until start_of_name.
// Stall: a two-entry output buffer plus the pending burst absorb a stalled
//   receiver; in_ch.ready then drops until space frees up.
// ----------------------------------------------------------------------------
module dns_name_wire_to_text_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [dnt_pkg::SIZE_W-1:0] cfg_wr_data,
  dnt_in_if.sink                     in_ch,
  dnt_out_if.source                  out_ch
);
  import dnt_pkg::*;

  in_item_t in_item;
  result_t  eng_data, out_data;
  logic     eng_valid, eng_ready;

  assign in_item.name_byte     = in_ch.name_byte;
  assign in_item.start_of_name = in_ch.start_of_name;

  dnt_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_item     (in_item),
    .res_valid   (eng_valid),
    .res_ready   (eng_ready),
    .res_data    (eng_data)
  );

  dnt_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (eng_valid),
    .up_ready (eng_ready),
    .up_data  (eng_data),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .dn_data  (out_data)
  );

  assign out_ch.out_char    = out_data.out_char;
  assign out_ch.char_valid  = out_data.char_valid;
  assign out_ch.last        = out_data.last;
  assign out_ch.status      = out_data.status;
  assign out_ch.text_length = out_data.text_length;

endmodule
